@@ sv/ept_pkg.sv @@
package ept_pkg;

  localparam int unsigned THR_W = 16;
  localparam int unsigned NUM_W = 48;
  localparam int unsigned TCK_W = 32;
  localparam int unsigned VEL_W = 32;
  localparam int unsigned POS_W = 48;
  localparam int unsigned PER_W = 32;

  localparam logic [TCK_W-1:0] TIMEOUT_RESET = 32'd50000000;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_EDGE = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_NUMERATOR = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_DONE,
    ST_MUL,
    ST_EMIT
  } state_t;

  // Control from the sequencer to a serial unit.
  typedef struct packed {
    logic start;
  } unit_ctl_t;

endpackage

@@ sv/ept_if.sv @@
interface ept_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  wheel;
  logic [31:0] period_ticks;
  modport source (output valid, output mode, output wheel, output period_ticks, input ready);
  modport sink (input valid, input mode, input wheel, input period_ticks, output ready);
endinterface

interface ept_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  wheel_index;
  logic [31:0] speed;
  logic [47:0] angle;
  logic        last;
  modport source (output valid, output wheel_index, output speed, output angle, output last,
                  input ready);
  modport sink (input valid, input wheel_index, input speed, input angle, input last,
                output ready);
endinterface

@@ sv/ept_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ept_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ept_pkg::unit_ctl_t     ctl,
  input  logic [47:0]            dividend,
  input  logic [31:0]            divisor,
  output logic                   done,
  output logic [31:0]            quotient
);
  import ept_pkg::*;

  logic [47:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[31:0], quo_r[47]};
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // Saturate the quotient at 32 bits.
  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = (quo_nxt[47:32] != '0) ? '1 : quo_nxt[31:0];

endmodule

@@ sv/ept_mac.sv @@
// Shift-add multiply-accumulate, one multiplier bit per cycle.
module ept_mac (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ept_pkg::unit_ctl_t     ctl,
  input  logic [31:0]            mcand,
  input  logic [31:0]            mplier,
  input  logic [47:0]            acc_in,
  output logic                   done,
  output logic [47:0]            acc_out
);
  import ept_pkg::*;

  logic [47:0] acc_r, acc_nxt;
  logic [47:0] mcd_r, mcd_nxt;
  logic [31:0] mpl_r, mpl_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  // Add the shifted multiplicand when the low multiplier bit is set.
  always_comb begin
    acc_nxt  = acc_r;
    mcd_nxt  = mcd_r;
    mpl_nxt  = mpl_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      acc_nxt  = acc_in;
      mcd_nxt  = {16'd0, mcand};
      mpl_nxt  = mplier;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mpl_r[0]) acc_nxt = acc_r + mcd_r;
      mcd_nxt = {mcd_r[46:0], 1'b0};
      mpl_nxt = {1'b0, mpl_r[31:1]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcd_r <= mcd_nxt;
    mpl_r <= mpl_nxt;
  end

  assign done    = busy_r && (cnt_r == 6'd1);
  assign acc_out = acc_nxt;

endmodule

@@ sv/encoder_period_tachometer.sv @@
// Tick items, edge items below threshold and updating edges that see zero elapsed
// ticks are done in the cycle they are taken; any other updating edge runs a bit-serial 48-bit divider.
// A read item runs a serial multiply-accumulate per wheel and then loads that wheel's
// result into the output register, wheel by wheel; the receiver may stall a result.
// One item is handled at a time.
// Reset (rst_n low, synchronous) clears all wheel state and sets the registers to defaults.
module encoder_period_tachometer #(
  parameter int unsigned WHEELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ept_in_if.sink      in_ch,
  ept_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ept_pkg::*;

  localparam int unsigned WI_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  // Configuration registers.
  logic [THR_W-1:0] thr_r;
  logic [NUM_W-1:0] num_r;
  logic [TCK_W-1:0] tmo_r;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      num_r <= '0;
      tmo_r <= TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_THRESHOLD: thr_r <= cfg_pwdata[THR_W-1:0];
        REG_NUMERATOR: num_r <= cfg_pwdata[NUM_W-1:0];
        REG_TIMEOUT:   tmo_r <= cfg_pwdata[TCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: cfg_prdata = {48'd0, thr_r};
      REG_NUMERATOR: cfg_prdata = {16'd0, num_r};
      REG_TIMEOUT:   cfg_prdata = {32'd0, tmo_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Per-wheel state.
  logic [THR_W-1:0] cnt_r [WHEELS];
  logic [TCK_W-1:0] ela_r [WHEELS];
  logic [VEL_W-1:0] vel_r [WHEELS];
  logic [POS_W-1:0] pos_r [WHEELS];

  state_t          st_r, st_nxt;
  logic [WI_W-1:0] wi_r;
  logic [PER_W-1:0] per_r;
  logic            ovalid_r;
  logic [1:0]      oidx_r;
  logic [VEL_W-1:0] ospd_r;
  logic [POS_W-1:0] oang_r;
  logic            olast_r;

  unit_ctl_t   div_ctl, mac_ctl;
  logic        div_done, mac_done;
  logic [31:0] div_q;
  logic [47:0] mac_acc;
  logic [31:0] div_dvs;
  logic [VEL_W-1:0] cur_vel;
  logic        cur_tmo;
  logic [WI_W-1:0] mac_wi;
  logic [PER_W-1:0] mac_mpl;

  logic in_xfer, is_edge_upd, edge_ok;
  logic last_wheel;
  logic emit_ld;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign edge_ok     = ({30'd0, in_ch.wheel} < 32'(WHEELS));
  assign is_edge_upd = edge_ok && (cnt_r[WI_W'(in_ch.wheel)] >= thr_r);
  assign div_dvs     = ela_r[WI_W'(in_ch.wheel)];
  assign last_wheel  = ({{(32-WI_W){1'b0}}, wi_r} == 32'(WHEELS - 1));
  assign emit_ld     = (st_r == ST_EMIT) && (!ovalid_r || out_ch.ready);

  // The multiply-accumulate starts on wheel 0 from idle and on the next wheel from emit.
  always_comb begin
    case (st_r)
      ST_IDLE: mac_wi = '0;
      ST_EMIT: mac_wi = last_wheel ? '0 : wi_r + 1'b1;
      default: mac_wi = wi_r;
    endcase
  end

  assign mac_mpl = (st_r == ST_IDLE) ? in_ch.period_ticks : per_r;
  assign cur_tmo = (ela_r[mac_wi] >= tmo_r);
  assign cur_vel = cur_tmo ? '0 : vel_r[mac_wi];

  ept_div u_div (.clk, .rst_n, .ctl(div_ctl), .dividend(num_r), .divisor(div_dvs),
                 .done(div_done), .quotient(div_q));
  ept_mac u_mac (.clk, .rst_n, .ctl(mac_ctl), .mcand(cur_vel), .mplier(mac_mpl),
                 .acc_in(pos_r[mac_wi]), .done(mac_done), .acc_out(mac_acc));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_t'(in_ch.mode) == MODE_READ) st_nxt = ST_MUL;
          else if (mode_t'(in_ch.mode) == MODE_EDGE && is_edge_upd && div_dvs != '0)
            st_nxt = ST_DIV;
        end
      end
      ST_DIV:      if (div_done) st_nxt = ST_DIV_DONE;
      ST_DIV_DONE: st_nxt = ST_IDLE;
      ST_MUL:      if (mac_done) st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!ovalid_r || out_ch.ready) st_nxt = last_wheel ? ST_IDLE : ST_MUL;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready   = (st_r == ST_IDLE);
    div_ctl.start = 1'b0;
    mac_ctl.start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        div_ctl.start = in_xfer && mode_t'(in_ch.mode) == MODE_EDGE && is_edge_upd;
        mac_ctl.start = in_xfer && mode_t'(in_ch.mode) == MODE_READ;
      end
      ST_EMIT: mac_ctl.start = (!ovalid_r || out_ch.ready) && !last_wheel;
      default: ;
    endcase
  end

  // Wheel state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) begin
        cnt_r[i] <= '0;
        ela_r[i] <= '0;
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
      st_r     <= ST_IDLE;
      wi_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit_ld) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_xfer && mode_t'(in_ch.mode) == MODE_EDGE && is_edge_upd)
            wi_r <= WI_W'(in_ch.wheel);
          else
            wi_r <= '0;
          if (in_xfer) begin
            case (mode_t'(in_ch.mode))
              MODE_TICK: begin
                for (int i = 0; i < WHEELS; i++)
                  if (ela_r[i] != '1) ela_r[i] <= ela_r[i] + 1'b1;
              end
              MODE_EDGE: begin
                if (edge_ok) begin
                  if (is_edge_upd) begin
                    cnt_r[WI_W'(in_ch.wheel)] <= '0;
                    ela_r[WI_W'(in_ch.wheel)] <= '0;
                  end else begin
                    cnt_r[WI_W'(in_ch.wheel)] <= cnt_r[WI_W'(in_ch.wheel)] + 1'b1;
                  end
                end
              end
              MODE_READ: per_r <= in_ch.period_ticks;
              default: ;
            endcase
          end
        end
        ST_DIV_DONE: ;
        ST_DIV: if (div_done) vel_r[wi_r] <= div_q;
        ST_MUL: begin
          if (mac_done) begin
            if (cur_tmo) begin
              vel_r[wi_r] <= '0;
              cnt_r[wi_r] <= '0;
            end
            pos_r[wi_r] <= mac_acc;
          end
        end
        ST_EMIT: begin
          if (emit_ld) begin
            oidx_r   <= 2'(wi_r);
            ospd_r   <= vel_r[wi_r];
            oang_r   <= pos_r[wi_r];
            olast_r  <= last_wheel;
            if (!last_wheel) wi_r <= wi_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.wheel_index = oidx_r;
  assign out_ch.speed       = ospd_r;
  assign out_ch.angle       = oang_r;
  assign out_ch.last        = olast_r;

endmodule

@@ sv/ept_checker.sv @@
module ept_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_wheel_index,
  input logic        out_last
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel_index))
    else $error("result changed while stalled");

  // No input is taken while a result other than the last is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken during a read");

  // The last flag only marks the top wheel.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_wheel_index == 2'd3)
    else $error("last on wrong wheel");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind encoder_period_tachometer ept_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_wheel_index(out_ch.wheel_index), .out_last(out_ch.last));

@@ tb/sv/encoder_period_tachometer_tb.sv @@
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the wheel state and predicts the
// per-wheel reports that each read transfer produces.
class tach_scoreboard;
  localparam int NW = 4;

  typedef struct packed {
    logic [1:0]  wheel_index;
    logic [31:0] speed;
    logic [47:0] angle;
    logic        last;
  } report_t;

  logic [15:0] threshold;
  logic [47:0] numerator;
  logic [31:0] timeout;
  logic [15:0] edge_cnt [NW];
  logic [31:0] ticks [NW];
  logic [31:0] vel [NW];
  logic [47:0] pos [NW];
  report_t     pending_reports[$];
  int          mismatches;
  int          reports_seen;
  int          reads_seen;

  function new();
    threshold = '0;
    numerator = '0;
    timeout = ept_pkg::TIMEOUT_RESET;
    for (int i = 0; i < NW; i++) begin
      edge_cnt[i] = '0;
      ticks[i] = '0;
      vel[i] = '0;
      pos[i] = '0;
    end
    mismatches = 0;
    reports_seen = 0;
    reads_seen = 0;
  endfunction

  function void set_reg(ept_pkg::reg_idx_t idx, logic [63:0] value);
    case (idx)
      ept_pkg::REG_THRESHOLD: threshold = value[15:0];
      ept_pkg::REG_NUMERATOR: numerator = value[47:0];
      ept_pkg::REG_TIMEOUT:   timeout = value[31:0];
      default: ;
    endcase
  endfunction

  // Updates the wheel state for one accepted input transfer.
  function void note_input(ept_pkg::mode_t mode, logic [1:0] wheel, logic [31:0] period);
    logic [63:0] quot;
    logic [31:0] dt;
    report_t     rep;
    case (mode)
      ept_pkg::MODE_TICK: begin
        for (int i = 0; i < NW; i++)
          if (ticks[i] != 32'hFFFF_FFFF) ticks[i] = ticks[i] + 32'd1;
      end
      ept_pkg::MODE_EDGE: begin
        if (edge_cnt[wheel] < threshold) begin
          edge_cnt[wheel] = edge_cnt[wheel] + 16'd1;
        end else begin
          edge_cnt[wheel] = '0;
          dt = ticks[wheel];
          ticks[wheel] = '0;
          if (dt != 0) begin
            quot = {16'd0, numerator} / {32'd0, dt};
            vel[wheel] = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
          end
        end
      end
      ept_pkg::MODE_READ: begin
        reads_seen++;
        for (int i = 0; i < NW; i++) begin
          if (ticks[i] >= timeout) begin
            vel[i] = '0;
            edge_cnt[i] = '0;
          end
          pos[i] = pos[i] + 48'({32'd0, vel[i]} * {32'd0, period});
          rep.wheel_index = 2'(i);
          rep.speed = vel[i];
          rep.angle = pos[i];
          rep.last = (i == NW - 1);
          pending_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  // Compares one accepted report with the oldest prediction.
  function void check_report(report_t got);
    report_t want;
    reports_seen++;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected report wheel=%0d speed=%h angle=%h last=%b",
                 got.wheel_index, got.speed, got.angle, got.last);
      return;
    end
    want = pending_reports.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: report exp wheel=%0d speed=%h angle=%h last=%b,",
                 want.wheel_index, want.speed, want.angle, want.last,
                 " got wheel=%0d speed=%h angle=%h last=%b",
                 got.wheel_index, got.speed, got.angle, got.last);
    end
  endfunction
endclass

module encoder_period_tachometer_tb;
  import ept_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  ept_in_if  in_ch ();
  ept_out_if out_ch ();

  encoder_period_tachometer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tach_scoreboard sb;
  int  cycles;
  bit  hold_off;
  bit  sender_done;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Input monitor: feeds every accepted transfer to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(mode_t'(in_ch.mode), in_ch.wheel, in_ch.period_ticks);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_report({out_ch.wheel_index, out_ch.speed, out_ch.angle, out_ch.last});
  end

  // Receiver: random stalls, mostly short, plus a long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one item and waits for its transfer, with an optional random gap first.
  task automatic send_item(mode_t mode, logic [1:0] wheel, logic [31:0] period, bit idle);
    int gap;
    if (idle && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.wheel <= wheel;
    in_ch.period_ticks <= period;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted report has arrived, then lets a divide finish.
  task automatic drain();
    go_idle();
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 3;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic configure(logic [15:0] thr, logic [47:0] num, logic [31:0] tmo);
    write_reg(REG_THRESHOLD, {48'd0, thr});
    write_reg(REG_NUMERATOR, {16'd0, num});
    write_reg(REG_TIMEOUT, {32'd0, tmo});
  endtask

  // Random period: mostly small, sometimes the extremes or all bits random.
  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom();
      2: return '0;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // Random phase: mostly tick/edge sequences with reads, some noise.
  task automatic random_phase(int count, int max_ticks, bit idle);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_item(MODE_TICK, 2'($urandom()), $urandom(), idle);
      else if (r < 75)
        send_item(MODE_EDGE, 2'($urandom()), $urandom(), idle);
      else if (r < 95)
        send_item(MODE_READ, 2'($urandom()), rand_period(), idle);
      else
        send_item(MODE_NONE, 2'($urandom()), $urandom(), idle);
      if (r < 10)
        for (int t = $urandom_range(0, max_ticks); t > 0; t--)
          send_item(MODE_TICK, 2'($urandom()), $urandom(), 1'b0);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_off = 1'b0;
    sender_done = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.wheel = '0;
    in_ch.period_ticks = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, an idle read, zero elapsed on an update edge.
    send_item(MODE_READ, 2'd0, 32'd7, 1'b0);
    send_item(MODE_EDGE, 2'd1, '0, 1'b0);
    send_item(MODE_NONE, 2'd3, 32'hFFFF_FFFF, 1'b0);
    drain();
    configure(16'd0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    // Quotient saturation, then position wrap with the largest period.
    send_item(MODE_TICK, 2'd3, '0, 1'b0);
    for (int w = 0; w < 4; w++) send_item(MODE_EDGE, 2'(w), '0, 1'b0);
    send_item(MODE_READ, 2'd2, 32'hFFFF_FFFF, 1'b0);
    send_item(MODE_READ, 2'd1, 32'hFFFF_FFFF, 1'b0);
    drain();
    // Zero timeout clears every wheel on read.
    configure(16'd2, 48'h0001_0000_0000, 32'd0);
    repeat (3) send_item(MODE_TICK, 2'd0, '0, 1'b0);
    repeat (3) send_item(MODE_EDGE, 2'd2, '0, 1'b0);
    send_item(MODE_READ, 2'd0, 32'd1000, 1'b0);
    drain();

    // Random phases over several settings, extremes included.
    configure(16'd1, 48'h0000_1234_5678, 32'd40);
    random_phase(40, 8, 1'b1);
    drain();
    configure(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'd1);
    random_phase(20, 3, 1'b1);
    drain();
    configure(16'd0, 48'h0000_0003_0000, 32'd25);
    // Long receiver hold-off while the sender keeps offering reads.
    hold_off = 1'b1;
    for (int n = 0; n < 8; n++) send_item(MODE_READ, 2'd0, rand_period(), 1'b0);
    random_phase(50, 20, 1'b1);
    drain();
    configure(16'($urandom()), 48'({$urandom(), $urandom()}), $urandom_range(1, 200));
    random_phase(50, 30, 1'b0);
    sender_done = 1'b1;
    drain();

    $display("Covered %0d reads and %0d wheel reports over seven register settings.",
             sb.reads_seen, sb.reports_seen);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d reports missing.", sb.mismatches,
               sb.pending_reports.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
